FILE: hdl/amsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package amsd_pkg;

  // Map geometry
  localparam int MAP_SIDE = 64;
  localparam int COL_W    = $clog2(MAP_SIDE);

  // Field widths
  localparam int PIX_W = 8;
  localparam int IDX_W = 12;
  localparam int CNT_W = 7;
  localparam int PCNT_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_EDGES    = 1'b1;

  // Alpha formats
  localparam logic [1:0] FMT_RLE    = 2'd0;
  localparam logic [1:0] FMT_PLAIN  = 2'd1;
  localparam logic [1:0] FMT_PACKED = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take in_byte and set up its pixel run
    logic push;   // emit one pixel of the current run
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;  // byte at the input makes no pixel
    logic last;      // pixel at hand ends the run or the map
    logic slot_ok;   // output register can take a result this cycle
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/amsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module amsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/amsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module amsd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire amsd_pkg::dp_status_t status,
  output amsd_pkg::ctl_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Sequence: take a byte, then push its pixels one per cycle while the output slot is free
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!status.cnt_zero) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (status.slot_ok) begin
          cmd.push = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/amsd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module amsd_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [amsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [amsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [amsd_pkg::PIX_W-1:0]        in_byte,
  input  wire amsd_pkg::ctl_cmd_t                cmd,
  output amsd_pkg::dp_status_t                   status,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [amsd_pkg::IDX_W-1:0]             out_first_index,
  output logic [amsd_pkg::PIX_W-1:0]             out_alpha_first,
  output logic [amsd_pkg::PIX_W-1:0]             out_alpha_second,
  output logic [amsd_pkg::PCNT_W-1:0]            out_pixel_count,
  output logic                                   out_map_done,
  output logic                                   out_last_of_run
);

  localparam int COL_W = amsd_pkg::COL_W;
  localparam int CNT_W = amsd_pkg::CNT_W;
  localparam int PIX_W = amsd_pkg::PIX_W;
  localparam int IDX_W = amsd_pkg::IDX_W;
  localparam logic [COL_W-1:0] SIDE_M1 = COL_W'(amsd_pkg::MAP_SIDE - 1);
  localparam logic [COL_W-1:0] SIDE_M2 = COL_W'(amsd_pkg::MAP_SIDE - 2);

  typedef enum logic [2:0] {
    PH_CTRL = 3'b001,
    PH_FILL = 3'b010,
    PH_COPY = 3'b100
  } phase_t;

  // Configuration
  logic [1:0] fmt_r;
  logic       fix_r;

  // Run-length decode state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] copy_r, copy_nxt, copy_dec;
  logic [CNT_W-1:0] cnt_load;

  // Current byte and its run
  logic [PIX_W-1:0] byte_r;
  logic [CNT_W-1:0] rem_r;
  logic             packed_r;

  // Position and pixel history
  logic [IDX_W-1:0] idx_r;
  logic [COL_W-1:0] col_r, col_nxt, row_r;
  logic [PIX_W-1:0] prev_r;

  // Half-built pair
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [PIX_W-1:0] pend_a_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] raw, pix, ram_rdata;
  logic             map_end, last, slot_ok, ram_we;

  // Decode the byte at the input for a load
  always_comb begin
    phase_nxt = phase_r;
    copy_nxt  = copy_r;
    copy_dec  = copy_r - CNT_W'(1);
    cnt_load  = '0;
    unique case (fmt_r)
      amsd_pkg::FMT_RLE: begin
        unique case (phase_r)
          PH_FILL: begin
            cnt_load  = copy_r;
            phase_nxt = PH_CTRL;
            copy_nxt  = '0;
          end
          PH_COPY: begin
            cnt_load = CNT_W'(1);
            copy_nxt = copy_dec;
            if (copy_dec == '0) begin
              phase_nxt = PH_CTRL;
            end
          end
          default: begin
            copy_nxt = in_byte[CNT_W-1:0];
            if (in_byte[PIX_W-1]) begin
              phase_nxt = PH_FILL;
            end else if (in_byte[CNT_W-1:0] != '0) begin
              phase_nxt = PH_COPY;
            end else begin
              phase_nxt = PH_CTRL;
            end
          end
        endcase
      end
      amsd_pkg::FMT_PACKED: cnt_load = CNT_W'(2);
      default:              cnt_load = CNT_W'(1);
    endcase
  end

  // Raw pixel: packed bytes give the low nibble first
  always_comb begin
    if (packed_r) begin
      raw = rem_r[1] ? {byte_r[3:0], 4'h0} : {byte_r[7:4], 4'h0};
    end else begin
      raw = byte_r;
    end
  end

  // Edge fix
  always_comb begin
    pix = raw;
    if (fix_r) begin
      if (col_r == SIDE_M1) begin
        pix = prev_r;
      end else if (row_r == SIDE_M1) begin
        pix = ram_rdata;
      end
    end
  end

  assign map_end = (col_r == SIDE_M1) && (row_r == SIDE_M1);
  assign last    = map_end || (rem_r == CNT_W'(1));
  assign slot_ok = !out_valid_r || !out_stall;
  assign ram_we  = cmd.push && (row_r == SIDE_M2);

  // Prefetch the line store at the column of the next pixel
  always_comb begin
    col_nxt = col_r;
    if (cmd.push) begin
      col_nxt = (col_r == SIDE_M1) ? '0 : col_r + COL_W'(1);
    end
  end

  assign status.cnt_zero = (cnt_load == '0);
  assign status.last     = last;
  assign status.slot_ok  = slot_ok;

  amsd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (amsd_pkg::MAP_SIDE)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (pix),
    .raddr (col_nxt),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= amsd_pkg::FMT_RLE;
      fix_r       <= 1'b1;
      phase_r     <= PH_CTRL;
      copy_r      <= '0;
      rem_r       <= '0;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      prev_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          amsd_pkg::CFG_ALPHA_FORMAT: fmt_r <= cfg_data;
          amsd_pkg::CFG_FIX_EDGES:    fix_r <= cfg_data[0];
          default: ;
        endcase
      end
      // Take the new phase on a load; drop the rest of a run at the end of the map
      if (cmd.load) begin
        phase_r <= phase_nxt;
        copy_r  <= copy_nxt;
      end else if (cmd.push && map_end) begin
        phase_r <= PH_CTRL;
        copy_r  <= '0;
      end
      col_r   <= col_nxt;
      if (cmd.load) begin
        rem_r <= cnt_load;
      end else if (cmd.push) begin
        rem_r <= rem_r - CNT_W'(1);
      end
      // Advance position
      if (cmd.push) begin
        prev_r <= pix;
        idx_r  <= map_end ? '0 : idx_r + IDX_W'(1);
        if (col_r == SIDE_M1) begin
          row_r <= (row_r == SIDE_M1) ? '0 : row_r + COL_W'(1);
        end
        pend_v_r <= !pend_v_r && !last;
      end
      // Transfer out or hold
      if (cmd.push && (pend_v_r || last)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r   <= in_byte;
      packed_r <= (fmt_r == amsd_pkg::FMT_PACKED);
    end
    if (cmd.push && !pend_v_r) begin
      pend_idx_r <= idx_r;
      pend_a_r   <= pix;
    end
    if (cmd.push && (pend_v_r || last)) begin
      out_map_done    <= map_end;
      out_last_of_run <= last;
      if (pend_v_r) begin
        out_first_index  <= pend_idx_r;
        out_alpha_first  <= pend_a_r;
        out_alpha_second <= pix;
        out_pixel_count  <= amsd_pkg::PCNT_W'(2);
      end else begin
        out_first_index  <= idx_r;
        out_alpha_first  <= pix;
        out_alpha_second <= '0;
        out_pixel_count  <= amsd_pkg::PCNT_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: hdl/alpha_map_stream_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                   Direction  Transfer
// input     in_valid, in_stall, in_byte             in         valid & !stall
// result    out_valid, out_stall, out_first_index,  out        valid & !stall
//           out_alpha_first/second, out_pixel_count,
//           out_map_done, out_last_of_run
// config    cfg_we, cfg_index, cfg_data             in         cfg_we
//
// A byte is loaded, then its pixels are pushed one per cycle while out_stall does
// not hold the result register: a control byte makes no pixel, a plain or copy
// byte one, a packed byte two, a fill of n pixels n. in_stall is high while pushing.
// Synchronous reset: run-length format, edge fix on, position zero. The
// 64-entry line store is not cleared; row 62 is written before row 63 reads it.
module alpha_map_stream_decoder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [amsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [amsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [amsd_pkg::PIX_W-1:0]        in_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [amsd_pkg::IDX_W-1:0]             out_first_index,
  output logic [amsd_pkg::PIX_W-1:0]             out_alpha_first,
  output logic [amsd_pkg::PIX_W-1:0]             out_alpha_second,
  output logic [amsd_pkg::PCNT_W-1:0]            out_pixel_count,
  output logic                                   out_map_done,
  output logic                                   out_last_of_run
);

  amsd_pkg::ctl_cmd_t   cmd;
  amsd_pkg::dp_status_t status;

  amsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  amsd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_byte          (in_byte),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_index  (out_first_index),
    .out_alpha_first  (out_alpha_first),
    .out_alpha_second (out_alpha_second),
    .out_pixel_count  (out_pixel_count),
    .out_map_done     (out_map_done),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire

FILE: test/alpha_map_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps
module alpha_map_stream_decoder_unit_tb;
  import amsd_pkg::*;

  localparam int MAP_PIXELS    = MAP_SIDE * MAP_SIDE;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 32;
  localparam int UNTYPED       = -1;

  // Format code with no meaning of its own; decodes as plain bytes
  localparam logic [1:0] FMT_UNUSED = 2'd3;
  // Edge fix register values; bit 1 is a don't-care bit of the port
  localparam logic [CFG_DATA_W-1:0] EDGE_FIX_ON       = 2'b01;
  localparam logic [CFG_DATA_W-1:0] EDGE_FIX_OFF      = 2'b00;
  localparam logic [CFG_DATA_W-1:0] EDGE_FIX_OFF_HIGH = 2'b10;

  typedef enum logic [1:0] {EXPECT_CTRL, FILL_VALUE, COPY_DATA} rle_phase_e;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [IDX_W-1:0]  first_index;
    logic [PIX_W-1:0]  alpha_first;
    logic [PIX_W-1:0]  alpha_second;
    logic [PCNT_W-1:0] pixel_count;
    logic              map_done;
    logic              last_of_run;
  } pixel_result_t;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [PIX_W-1:0]      data;
    int                    n_typed;
    pixel_result_t         want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_W-1:0]      out_first_index;
  logic [PIX_W-1:0]      out_alpha_first;
  logic [PIX_W-1:0]      out_alpha_second;
  logic [PCNT_W-1:0]     out_pixel_count;
  logic                  out_map_done;
  logic                  out_last_of_run;

  alpha_map_stream_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_index  (out_first_index),
    .out_alpha_first  (out_alpha_first),
    .out_alpha_second (out_alpha_second),
    .out_pixel_count  (out_pixel_count),
    .out_map_done     (out_map_done),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Decoder state mirrored by the testbench
  logic [1:0]       cur_format;
  bit               edge_fix_on;
  int unsigned      raster_pos;
  rle_phase_e       rle_phase;
  logic [6:0]       run_left;
  logic [PIX_W-1:0] last_alpha;
  logic [PIX_W-1:0] row62_alpha [MAP_SIDE];
  int               pair_n;
  pixel_result_t    pair_acc;

  pixel_result_t byte_results[$];
  pixel_result_t alpha_expect_q[$];
  stim_row_t     directed_rows[$];

  int            mismatches = 0;
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;
  bit            typed_due = 1'b0;
  int            typed_n;
  pixel_result_t typed_want;
  int unsigned   cycle_count;

  function automatic void reset_model();
    cur_format  = FMT_RLE;
    edge_fix_on = 1'b1;
    raster_pos  = 0;
    rle_phase   = EXPECT_CTRL;
    run_left    = '0;
    last_alpha  = '0;
    pair_n      = 0;
    foreach (row62_alpha[c]) row62_alpha[c] = '0;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string fname, logic [IDX_W-1:0] at_index,
                                      logic [11:0] want, logic [11:0] got);
    if (got !== want)
      note_mismatch($sformatf("pixel %h %s: expected %h, got %h", at_index, fname, want, got));
  endfunction

  // Close the pixel pair being collected and queue it as a result
  function automatic void flush_pair(bit done);
    pixel_result_t r;
    if (pair_n == 0) return;
    r = pair_acc;
    if (pair_n != 2) r.alpha_second = '0;
    r.pixel_count = pair_n[PCNT_W-1:0];
    r.map_done    = done;
    r.last_of_run = 1'b0;
    byte_results.push_back(r);
    pair_n = 0;
  endfunction

  // Place one pixel at the current raster position; returns 1 when the map ends
  function automatic bit push_alpha(logic [PIX_W-1:0] raw);
    int unsigned col;
    int unsigned row;
    logic [PIX_W-1:0] v;
    col = raster_pos % MAP_SIDE;
    row = raster_pos / MAP_SIDE;
    v = raw;
    if (edge_fix_on) begin
      if (col == MAP_SIDE - 1) v = last_alpha;
      else if (row == MAP_SIDE - 1) v = row62_alpha[col];
    end
    if (row == MAP_SIDE - 2) row62_alpha[col] = v;
    last_alpha = v;
    if (pair_n == 0) begin
      pair_acc.first_index = raster_pos[IDX_W-1:0];
      pair_acc.alpha_first = v;
      pair_n = 1;
    end else begin
      pair_acc.alpha_second = v;
      pair_n = 2;
    end
    raster_pos++;
    if (raster_pos >= MAP_PIXELS) begin
      flush_pair(1'b1);
      raster_pos = 0;
      rle_phase  = EXPECT_CTRL;
      run_left   = '0;
      return 1'b1;
    end
    if (pair_n == 2) flush_pair(1'b0);
    return 1'b0;
  endfunction

  // Work out every result that one accepted byte causes
  function automatic void decode_byte(logic [PIX_W-1:0] b);
    int unsigned n;
    byte_results.delete();
    pair_n = 0;
    if (cur_format == FMT_RLE) begin
      case (rle_phase)
        FILL_VALUE: begin
          n = run_left;
          rle_phase = EXPECT_CTRL;
          run_left = '0;
          for (int unsigned k = 0; k < n; k++)
            if (push_alpha(b)) break;
        end
        COPY_DATA: begin
          run_left = run_left - 7'd1;
          if (run_left == '0) rle_phase = EXPECT_CTRL;
          void'(push_alpha(b));
        end
        default: begin
          run_left = b[6:0];
          if (b[7]) rle_phase = FILL_VALUE;
          else rle_phase = (run_left != '0) ? COPY_DATA : EXPECT_CTRL;
        end
      endcase
    end else if (cur_format == FMT_PACKED) begin
      if (!push_alpha({b[3:0], 4'h0})) void'(push_alpha({b[7:4], 4'h0}));
    end else begin
      void'(push_alpha(b));
    end
    flush_pair(1'b0);
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
  endfunction

  // Track register writes and accepted bytes; compare every result transfer
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA_FORMAT: cur_format = cfg_data[1:0];
          CFG_FIX_EDGES:    edge_fix_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        if (typed_due) begin
          typed_due = 1'b0;
          if (byte_results.size() != typed_n ||
              (typed_n == 1 && byte_results[0] !== typed_want))
            note_mismatch($sformatf("byte %h: table gives %0d result(s) %h, predicted %0d",
                                    in_byte, typed_n, typed_want, byte_results.size()));
        end
        foreach (byte_results[k]) alpha_expect_q.push_back(byte_results[k]);
      end
      if (out_valid && !out_stall) begin
        if (alpha_expect_q.size() == 0) begin
          note_mismatch($sformatf("result at pixel %h with nothing expected", out_first_index));
        end else begin
          want = alpha_expect_q.pop_front();
          check_field("first_index", want.first_index, 12'(want.first_index), out_first_index);
          check_field("alpha_first", want.first_index, 12'(want.alpha_first),
                      12'(out_alpha_first));
          check_field("alpha_second", want.first_index, 12'(want.alpha_second),
                      12'(out_alpha_second));
          check_field("pixel_count", want.first_index, 12'(want.pixel_count),
                      12'(out_pixel_count));
          check_field("map_done", want.first_index, 12'(want.map_done), 12'(out_map_done));
          check_field("last_of_run", want.first_index, 12'(want.last_of_run),
                      12'(out_last_of_run));
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[alpha_map_stream_decoder_unit] ERROR");
    $finish;
  end

  function automatic pixel_result_t one_px(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] a);
    return '{first_index: idx, alpha_first: a, alpha_second: '0, pixel_count: 2'd1,
             map_done: 1'b0, last_of_run: 1'b1};
  endfunction

  function automatic pixel_result_t two_px(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] a,
                                           logic [PIX_W-1:0] b);
    return '{first_index: idx, alpha_first: a, alpha_second: b, pixel_count: 2'd2,
             map_done: 1'b0, last_of_run: 1'b1};
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, data: '0, n_typed: UNTYPED, want: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_byte(logic [PIX_W-1:0] b, int n_typed = UNTYPED,
                                   pixel_result_t want = '0);
    stim_row_t r;
    r = '{kind: ROW_BYTE, reg_idx: '0, reg_val: '0, data: b, n_typed: n_typed, want: want};
    directed_rows.push_back(r);
  endfunction

  // Offer one byte, with an optional idle burst first; return once it transfers
  task automatic send_byte(logic [PIX_W-1:0] b, int n_typed = UNTYPED,
                           pixel_result_t want = '0);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    typed_due  = (n_typed != UNTYPED);
    typed_n    = n_typed;
    typed_want = want;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off input until every pending result is out, then let the block settle
  task automatic drain(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (alpha_expect_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic byte_traffic(int n_items);
    repeat (n_items) send_byte(8'($urandom));
  endtask

  // Mostly well-formed fill and copy runs, long fills to cross whole rows, some noise
  task automatic rle_traffic(int n_items);
    int sent;
    int pick;
    int run;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_byte(8'($urandom));
        sent++;
      end else if (pick < 75) begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(64, 127);
        send_byte({1'b1, run[6:0]});
        send_byte(8'($urandom));
        sent += 2;
      end else begin
        run = ($urandom_range(0, 49) == 0) ? 127 : $urandom_range(0, 8);
        send_byte({1'b0, run[6:0]});
        repeat (run) send_byte(8'($urandom));
        sent += run + 1;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_byte   = '0;

    // Plain and packed bytes from position zero, then the unused format code
    add_cfg(CFG_ALPHA_FORMAT, FMT_PLAIN);
    add_byte(8'h00, 1, one_px(12'd0, 8'h00));
    add_byte(8'hFF, 1, one_px(12'd1, 8'hFF));
    add_cfg(CFG_ALPHA_FORMAT, FMT_PACKED);
    add_byte(8'h0F, 1, two_px(12'd2, 8'hF0, 8'h00));
    add_byte(8'hF0, 1, two_px(12'd4, 8'h00, 8'hF0));
    add_byte(8'hA5, 1, two_px(12'd6, 8'h50, 8'hA0));
    add_cfg(CFG_ALPHA_FORMAT, FMT_UNUSED);
    add_byte(8'h5A, 1, one_px(12'd8, 8'h5A));
    // Zero-length copy and fill emit nothing, then a short copy
    add_cfg(CFG_ALPHA_FORMAT, FMT_RLE);
    add_byte(8'h00, 0);
    add_byte(8'h80, 0);
    add_byte(8'h33, 0);
    add_byte(8'h03, 0);
    add_byte(8'h00, 1, one_px(12'd9, 8'h00));
    add_byte(8'hFF, 1, one_px(12'd10, 8'hFF));
    add_byte(8'h7E, 1, one_px(12'd11, 8'h7E));
    // Longest fill: 64 results, crosses column 63 twice
    add_byte(8'hFF, 0);
    add_byte(8'hC3);
    // Edge fix off, odd-length fills, a copy ending on a byte with bit 7 set
    add_cfg(CFG_FIX_EDGES, EDGE_FIX_OFF_HIGH);
    add_byte(8'h85, 0);
    add_byte(8'h11);
    add_byte(8'h81, 0);
    add_byte(8'hEE, 1, one_px(12'd144, 8'hEE));
    add_byte(8'h02, 0);
    add_byte(8'h01);
    add_byte(8'h80);
    add_cfg(CFG_FIX_EDGES, EDGE_FIX_ON);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain(SETTLE_CYCLES);
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        send_byte(directed_rows[r].data, directed_rows[r].n_typed, directed_rows[r].want);
      end
    end

    // Run-length maps with the edge fix on; long receiver hold-off, then a full pause
    rle_traffic(100);
    hold_req = 1'b1;
    rle_traffic(60);
    drain(SETTLE_CYCLES);
    rle_traffic(100);

    drain(SETTLE_CYCLES);
    write_reg(CFG_ALPHA_FORMAT, FMT_PLAIN);
    write_reg(CFG_FIX_EDGES, EDGE_FIX_OFF);
    byte_traffic(40);

    drain(SETTLE_CYCLES);
    write_reg(CFG_ALPHA_FORMAT, FMT_PACKED);
    write_reg(CFG_FIX_EDGES, EDGE_FIX_ON);
    byte_traffic(50);

    drain(SETTLE_CYCLES);
    write_reg(CFG_ALPHA_FORMAT, FMT_UNUSED);
    byte_traffic(20);

    // Back to run-length mid-map, edge fix off; no idling toward the end
    drain(SETTLE_CYCLES);
    write_reg(CFG_ALPHA_FORMAT, FMT_RLE);
    write_reg(CFG_FIX_EDGES, EDGE_FIX_OFF);
    rle_traffic(30);
    quiet = 1'b1;
    rle_traffic(50);

    drain(TAIL_CYCLES);
    if (mismatches == 0 && alpha_expect_q.size() == 0)
      $display("[alpha_map_stream_decoder_unit] OK");
    else
      $display("[alpha_map_stream_decoder_unit] ERROR");
    $finish;
  end

endmodule
